@@ sv/mfs_pkg.sv @@
// mfs_pkg: sizes, status codes and controller/datapath command types
// for the maximum frequency stack. No dependencies.
package mfs_pkg;
	localparam int CAPACITY   = 64;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int LINK_W     = IDX_W + 1;
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(CAPACITY);

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_SCAN_START,
		CMD_SCAN_STEP,
		CMD_PUSH_LVL,
		CMD_PUSH_WR,
		CMD_POP_LVL,
		CMD_POP_HEAD,
		CMD_POP_ENT,
		CMD_POP_WR,
		CMD_ERR_EMPTY,
		CMD_ERR_FULL,
		CMD_OUT
	} cmd_e_t;

	typedef struct packed {
		cmd_e_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic is_pop;
		logic full;
		logic empty;
		logic scan_done;
		logic push_bad;
	} dp_stat_t;
endpackage

@@ sv/mfs_ram.sv @@
// mfs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module mfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/mfs_datapath.sv @@
// mfs_datapath: count table, entry and level-head memories, occupancy bits
// and result registers. Depends on mfs_pkg and mfs_ram.
module mfs_datapath
	import mfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	input  logic                  req_type,
	input  logic [DATA_WIDTH-1:0] value,
	output dp_stat_t              stat,
	output logic [DATA_WIDTH-1:0] popped_value,
	output logic [1:0]            status
);
	localparam int SW = DATA_WIDTH + LINK_W;

	logic                  type_q;
	logic [DATA_WIDTH-1:0] value_q;
	logic [CAPACITY-1:0]   used_q, lvl_valid_q, free_q;
	logic [LINK_W-1:0]     top_q, count_q;
	logic [IDX_W-1:0]      lvl_q, ent_q, slot_q;
	logic [LINK_W-1:0]     below_q, cnew_q;

	logic [LINK_W-1:0]     scan_i_q;
	logic                  scan_v_s1;
	logic [IDX_W-1:0]      scan_j_s1;
	logic                  hit_q, fslot_ok_q, fent_ok_q;
	logic [IDX_W-1:0]      hslot_q, fslot_q, fent_q;
	logic [LINK_W-1:0]     cnt_q;

	logic [DATA_WIDTH-1:0] res_value_q;
	logic [1:0]            res_status_q;

	logic              slot_we, ent_we, head_we;
	logic [IDX_W-1:0]  slot_waddr, head_waddr;
	logic [SW-1:0]     slot_wdata, slot_rdata, ent_wdata, ent_rdata;
	logic [IDX_W-1:0]  head_wdata, head_rdata;
	logic [IDX_W-1:0]  scan_idx;
	logic [LINK_W-1:0] push_below;

	assign scan_idx   = scan_i_q[IDX_W-1:0];
	assign push_below = lvl_valid_q[lvl_q] ? {1'b0, head_rdata} : NULL_LINK;

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = {value_q, cnew_q};
		ent_we     = 1'b0;
		ent_wdata  = {value_q, push_below};
		head_we    = 1'b0;
		head_waddr = lvl_q;
		head_wdata = fent_q;
		case (cmd.op)
			CMD_PUSH_WR: begin
				slot_we = 1'b1;
				ent_we  = 1'b1;
				head_we = 1'b1;
			end
			CMD_POP_WR: begin
				slot_we    = hit_q;
				slot_waddr = hslot_q;
				slot_wdata = {value_q, cnt_q - LINK_W'(1)};
				head_we    = (below_q != NULL_LINK);
				head_wdata = below_q[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	mfs_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.raddr(scan_idx), .rdata(slot_rdata)
	);

	mfs_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_ent_ram (
		.clk(clk), .we(ent_we), .waddr(fent_q), .wdata(ent_wdata),
		.raddr(ent_q), .rdata(ent_rdata)
	);

	mfs_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_head_ram (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(lvl_q), .rdata(head_rdata)
	);

	always_comb begin
		stat.is_pop    = (type_q == REQ_POP);
		stat.full      = (count_q == LINK_W'(CAPACITY));
		stat.empty     = (count_q == '0) || (top_q == '0);
		stat.scan_done = (scan_i_q == LINK_W'(CAPACITY)) && !scan_v_s1;
		stat.push_bad  = (!hit_q && !fslot_ok_q) || !fent_ok_q ||
			(hit_q && cnt_q >= LINK_W'(CAPACITY));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			lvl_valid_q  <= '0;
			free_q       <= '1;
			top_q        <= '0;
			count_q      <= '0;
			scan_i_q     <= LINK_W'(CAPACITY);
			scan_v_s1    <= 1'b0;
			hit_q        <= 1'b0;
			fslot_ok_q   <= 1'b0;
			fent_ok_q    <= 1'b0;
			popped_value <= '0;
			status       <= STAT_OK;
		end else begin
			if (scan_v_s1 && !hit_q && used_q[scan_j_s1] &&
				slot_rdata[SW-1:LINK_W] == value_q) begin
				hit_q   <= 1'b1;
				hslot_q <= scan_j_s1;
				cnt_q   <= slot_rdata[LINK_W-1:0];
			end
			case (cmd.op)
				CMD_LOAD: begin
					type_q  <= req_type;
					value_q <= value;
				end
				CMD_SCAN_START, CMD_POP_ENT: begin
					scan_i_q   <= '0;
					scan_v_s1  <= 1'b0;
					hit_q      <= 1'b0;
					fslot_ok_q <= 1'b0;
					fent_ok_q  <= 1'b0;
					if (cmd.op == CMD_POP_ENT) begin
						value_q <= ent_rdata[SW-1:LINK_W];
						below_q <= ent_rdata[LINK_W-1:0];
					end
				end
				CMD_SCAN_STEP: begin
					if (scan_i_q != LINK_W'(CAPACITY)) begin
						scan_v_s1 <= 1'b1;
						scan_j_s1 <= scan_idx;
						scan_i_q  <= scan_i_q + LINK_W'(1);
						if (!fslot_ok_q && !used_q[scan_idx]) begin
							fslot_ok_q <= 1'b1;
							fslot_q    <= scan_idx;
						end
						if (!fent_ok_q && free_q[scan_idx]) begin
							fent_ok_q <= 1'b1;
							fent_q    <= scan_idx;
						end
					end else begin
						scan_v_s1 <= 1'b0;
					end
				end
				CMD_PUSH_LVL: begin
					cnew_q <= hit_q ? cnt_q + LINK_W'(1) : LINK_W'(1);
					lvl_q  <= hit_q ? cnt_q[IDX_W-1:0] : '0;
					slot_q <= hit_q ? hslot_q : fslot_q;
				end
				CMD_PUSH_WR: begin
					used_q[slot_q]     <= 1'b1;
					lvl_valid_q[lvl_q] <= 1'b1;
					free_q[fent_q]     <= 1'b0;
					if (cnew_q > top_q) begin
						top_q <= cnew_q;
					end
					count_q      <= count_q + LINK_W'(1);
					res_value_q  <= '0;
					res_status_q <= STAT_OK;
				end
				CMD_POP_LVL: lvl_q <= IDX_W'(top_q - LINK_W'(1));
				CMD_POP_HEAD: ent_q <= head_rdata;
				CMD_POP_WR: begin
					free_q[ent_q] <= 1'b1;
					count_q       <= count_q - LINK_W'(1);
					if (hit_q && cnt_q == LINK_W'(1)) begin
						used_q[hslot_q] <= 1'b0;
					end
					if (below_q == NULL_LINK) begin
						lvl_valid_q[lvl_q] <= 1'b0;
						top_q              <= top_q - LINK_W'(1);
					end
					res_value_q  <= value_q;
					res_status_q <= STAT_OK;
				end
				CMD_ERR_EMPTY: begin
					res_value_q  <= '0;
					res_status_q <= STAT_EMPTY;
				end
				CMD_ERR_FULL: begin
					res_value_q  <= '0;
					res_status_q <= STAT_FULL;
				end
				CMD_OUT: begin
					popped_value <= res_value_q;
					status       <= res_status_q;
				end
				default: begin
				end
			endcase
		end
	end
endmodule

@@ sv/mfs_ctrl.sv @@
// mfs_ctrl: request sequencer for push and pop, drives datapath commands
// and the handshakes. Depends on mfs_pkg.
module mfs_ctrl
	import mfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_CHK, ST_SCAN, ST_P_WAIT, ST_P_WR,
		ST_O_WAIT1, ST_O_HEAD, ST_O_WAIT2, ST_O_ENT, ST_O_WR, ST_RESP
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = CMD_NONE;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = CMD_LOAD;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				if (stat.is_pop) begin
					if (stat.empty) begin
						cmd.op  = CMD_ERR_EMPTY;
						state_d = ST_RESP;
					end else begin
						cmd.op  = CMD_POP_LVL;
						state_d = ST_O_WAIT1;
					end
				end else if (stat.full) begin
					cmd.op  = CMD_ERR_FULL;
					state_d = ST_RESP;
				end else begin
					cmd.op  = CMD_SCAN_START;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.op = CMD_SCAN_STEP;
				if (stat.scan_done) begin
					if (stat.is_pop) begin
						state_d = ST_O_WR;
					end else if (stat.push_bad) begin
						cmd.op  = CMD_ERR_FULL;
						state_d = ST_RESP;
					end else begin
						cmd.op  = CMD_PUSH_LVL;
						state_d = ST_P_WAIT;
					end
				end
			end
			ST_P_WAIT: state_d = ST_P_WR;
			ST_P_WR: begin
				cmd.op  = CMD_PUSH_WR;
				state_d = ST_RESP;
			end
			ST_O_WAIT1: state_d = ST_O_HEAD;
			ST_O_HEAD: begin
				cmd.op  = CMD_POP_HEAD;
				state_d = ST_O_WAIT2;
			end
			ST_O_WAIT2: state_d = ST_O_ENT;
			ST_O_ENT: begin
				cmd.op  = CMD_POP_ENT;
				state_d = ST_SCAN;
			end
			ST_O_WR: begin
				cmd.op  = CMD_POP_WR;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!out_valid || out_ready) begin
					cmd.op  = CMD_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.op == CMD_OUT) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule

@@ sv/max_frequency_stack_core.sv @@
// max_frequency_stack_core: top level of the maximum frequency stack.
// Depends on mfs_pkg, mfs_ctrl, mfs_datapath.
//
// Input channel (in_valid/in_ready): one request, req_type 0 pushes value,
// req_type 1 pops the most frequent value (newest wins ties).
// Output channel (out_valid/out_ready): exactly one result per request,
// popped_value (zero unless a pop succeeds) and status (0 ok, 1 pop while
// empty, 2 push while full).
// One request is worked at a time. Each push or pop that passes its first check
// sweeps the 64-slot count table through its RAM read port, one slot a cycle;
// a request rejected at that check as full or empty skips the sweep. The next
// request is taken as soon as the previous result sits in the output register,
// even if the receiver has not taken it.
// Reset clears all occupancy bits, levels and counts at once; no clearing
// pass. If the receiver stalls, the result is held and the following request
// waits in its last step until the output register frees.
module max_frequency_stack_core
	import mfs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [DATA_WIDTH-1:0] value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [31:0]           popped_value,
	output logic [1:0]            status
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	mfs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	mfs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .req_type(req_type), .value(value),
		.stat(stat), .popped_value(popped_value), .status(status)
	);
endmodule

@@ sv/mfs_checker.sv @@
// mfs_checker: port-level assertions for max_frequency_stack_core, with bind.
// Depends on mfs_pkg.
module mfs_checker
	import mfs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] popped_value,
	input logic [1:0]  status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(popped_value) && $stable(status))
		else $error("result changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL))
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> popped_value == '0)
		else $error("failed request returned a value");

	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");
endmodule

bind max_frequency_stack_core mfs_checker u_mfs_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.popped_value(popped_value), .status(status)
);
